FILE: hw/rtl/accumulator_machine_16bit_unit_defines.svh
// Assertion macros used by the accumulator machine control module.
`ifndef ACCUMULATOR_MACHINE_16BIT_UNIT_DEFINES_SVH
`define ACCUMULATOR_MACHINE_16BIT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define AMU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("amu: property failed");
`define AMU_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("amu: forbidden condition seen");
`else
`define AMU_ASSERT(lbl, prop)
`define AMU_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hw/rtl/amu_pkg.sv
package amu_pkg;

	localparam int DEF_MEM_DEPTH = 4096;
	localparam int WORD_W = 16;
	localparam int PC_OUT_W = 13;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_START = 2'd1,
		FN_EXEC  = 2'd2
	} fn_t;

	typedef enum logic [2:0] {
		OP_BAN = 3'd0,
		OP_SUB = 3'd1,
		OP_STC = 3'd2,
		OP_AND = 3'd3,
		OP_ADD = 3'd4,
		OP_LD  = 3'd5,
		OP_BR  = 3'd6,
		OP_SYS = 3'd7
	} op_t;

	localparam logic [11:0] SYS_RD  = 12'd1;
	localparam logic [11:0] SYS_STP = 12'd2;
	localparam logic [11:0] SYS_WRT = 12'd3;

	typedef enum logic [2:0] {
		RS_RUNNING = 3'd0,
		RS_IDLE    = 3'd1,
		RS_STOPPED = 3'd2,
		RS_BADINSN = 3'd3,
		RS_BADADDR = 3'd4,
		RS_PASTEND = 3'd5
	} rs_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_DECODE,
		S_POINTER,
		S_OPERAND
	} state_t;

	typedef enum logic {
		RSEL_PC,
		RSEL_DATA
	} rsel_t;

	typedef enum logic [1:0] {
		WSEL_NONE,
		WSEL_LOAD,
		WSEL_CLEAR,
		WSEL_STORE
	} wsel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_ZERO,
		ACC_READ,
		ACC_ALU
	} acc_op_t;

	typedef enum logic [1:0] {
		PC_HOLD,
		PC_ZERO,
		PC_NEXT,
		PC_JUMP
	} pc_op_t;

	typedef struct packed {
		logic    item_clr;
		logic    rd_en;
		rsel_t   rd_sel;
		wsel_t   wr_sel;
		logic    ir_we;
		acc_op_t acc_op;
		pc_op_t  pc_op;
		logic    rs_we;
		rs_t     rs_val;
		logic    wv_set;
		logic    rt_set;
	} cmd_t;

	typedef struct packed {
		logic        running;
		logic        pc_past;
		op_t         op;
		logic        ind;
		logic [11:0] target;
		logic        acc_neg;
		logic        data_bad;
		logic        tgt_bad_dir;
		logic        tgt_bad_ind;
		logic        clr_last;
		op_t         ir_op;
	} sts_t;

endpackage

FILE: hw/rtl/amu_dpath.sv
module amu_dpath import amu_pkg::*; #(
	parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [11:0]         load_address,
	input  logic [WORD_W-1:0]   load_word,
	input  logic [WORD_W-1:0]   read_value,
	output logic [WORD_W-1:0]   accumulator,
	output logic [PC_OUT_W-1:0] program_counter,
	output logic [2:0]          status,
	output logic                write_valid,
	output logic [WORD_W-1:0]   write_value,
	output logic                read_taken
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] PC_END = PW'(MEM_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);
	localparam logic [16:0] DEPTH_17 = 17'(MEM_DEPTH);
	localparam logic [12:0] DEPTH_13 = 13'(MEM_DEPTH);

	logic [WORD_W-1:0] mem_q [MEM_DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [WORD_W-1:0] ir_q;
	logic [WORD_W-1:0] rv_q;
	logic [WORD_W-1:0] acc_q;
	logic [PW-1:0]     pc_q;
	rs_t               rs_q;
	logic              wv_q;
	logic              rt_q;
	logic [WORD_W-1:0] wval_q;
	logic [AW-1:0]     clr_q;

	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              wr_en;
	logic [PW-1:0]     pc_inc;
	logic [WORD_W-1:0] alu_res;
	logic              load_ok;

	assign load_ok = {1'b0, load_address} < DEPTH_13;
	assign rd_addr = (cmd.rd_sel == RSEL_PC) ? pc_q[AW-1:0] : rdata_q[AW-1:0];
	assign pc_inc  = pc_q + 1'b1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rdata_q[AW-1:0];
		wr_data = acc_q;
		case (cmd.wr_sel)
			WSEL_LOAD: begin
				wr_en   = load_ok;
				wr_addr = load_address[AW-1:0];
				wr_data = load_word;
			end
			WSEL_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '1;
			end
			WSEL_STORE: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (cmd.ir_we) begin
			ir_q <= rdata_q;
		end
		if (cmd.item_clr) begin
			rv_q <= read_value;
		end
	end

	always_comb begin
		case (op_t'(ir_q[15:13]))
			OP_SUB:  alu_res = acc_q - rdata_q;
			OP_AND:  alu_res = acc_q & rdata_q;
			OP_ADD:  alu_res = acc_q + rdata_q;
			OP_LD:   alu_res = rdata_q;
			default: alu_res = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pc_q   <= '0;
			rs_q   <= RS_IDLE;
			wv_q   <= 1'b0;
			rt_q   <= 1'b0;
			wval_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.wr_sel == WSEL_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.item_clr) begin
				wv_q   <= 1'b0;
				rt_q   <= 1'b0;
				wval_q <= '0;
			end
			if (cmd.wv_set) begin
				wv_q   <= 1'b1;
				wval_q <= acc_q;
			end
			if (cmd.rt_set) begin
				rt_q <= 1'b1;
			end
			case (cmd.acc_op)
				ACC_ZERO: acc_q <= '0;
				ACC_READ: acc_q <= rv_q;
				ACC_ALU:  acc_q <= alu_res;
				default:  acc_q <= acc_q;
			endcase
			if (cmd.rs_we) begin
				rs_q <= cmd.rs_val;
			end
			case (cmd.pc_op)
				PC_ZERO: pc_q <= '0;
				PC_NEXT: begin
					pc_q <= pc_inc;
					if (pc_inc == PC_END) begin
						rs_q <= RS_PASTEND;
					end
				end
				PC_JUMP: pc_q <= {1'b0, rdata_q[AW-1:0]};
				default: pc_q <= pc_q;
			endcase
		end
	end

	always_comb begin
		sts.running     = (rs_q == RS_RUNNING);
		sts.pc_past     = (pc_q >= PC_END);
		sts.op          = op_t'(rdata_q[15:13]);
		sts.ind         = rdata_q[12];
		sts.target      = rdata_q[11:0];
		sts.acc_neg     = acc_q[15];
		sts.data_bad    = ({1'b0, rdata_q} >= DEPTH_17);
		sts.tgt_bad_dir = ({1'b0, rdata_q[11:0]} >= DEPTH_13);
		sts.tgt_bad_ind = (rdata_q[11:8] != 4'd0) || sts.tgt_bad_dir;
		sts.clr_last    = (clr_q == CLR_LAST);
		sts.ir_op       = op_t'(ir_q[15:13]);
	end

	assign accumulator     = acc_q;
	assign program_counter = PC_OUT_W'(pc_q);
	assign status          = rs_q;
	assign write_valid     = wv_q;
	assign write_value     = wval_q;
	assign read_taken      = rt_q;

endmodule

FILE: hw/rtl/amu_ctrl.sv
`include "accumulator_machine_16bit_unit_defines.svh"

module amu_ctrl import amu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] func,
	output logic       busy,
	output logic       done,
	output cmd_t       cmd,
	input  sts_t       sts
);

	state_t state_q, state_d;
	logic   done_q, done_d;
	logic   resolve;
	op_t    act_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		resolve = 1'b0;
		act_op  = sts.ir_op;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_sel = WSEL_CLEAR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.item_clr = 1'b1;
					done_d       = 1'b1;
					unique case (fn_t'(func))
						FN_LOAD: begin
							cmd.wr_sel = WSEL_LOAD;
						end
						FN_START: begin
							cmd.acc_op = ACC_ZERO;
							cmd.pc_op  = PC_ZERO;
							cmd.rs_we  = 1'b1;
							cmd.rs_val = RS_RUNNING;
						end
						FN_EXEC: begin
							if (sts.running && sts.pc_past) begin
								cmd.rs_we  = 1'b1;
								cmd.rs_val = RS_PASTEND;
							end else if (sts.running) begin
								done_d  = 1'b0;
								state_d = S_FETCH;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RSEL_PC;
				state_d    = S_DECODE;
			end
			S_DECODE: begin
				cmd.ir_we = 1'b1;
				act_op    = sts.op;
				state_d   = S_IDLE;
				done_d    = 1'b1;
				if (sts.op == OP_SYS) begin
					unique case (sts.target)
						SYS_RD: begin
							cmd.acc_op = ACC_READ;
							cmd.rt_set = 1'b1;
							cmd.pc_op  = PC_NEXT;
						end
						SYS_STP: begin
							cmd.rs_we  = 1'b1;
							cmd.rs_val = RS_STOPPED;
						end
						SYS_WRT: begin
							cmd.wv_set = 1'b1;
							cmd.pc_op  = PC_NEXT;
						end
						default: begin
							cmd.rs_we  = 1'b1;
							cmd.rs_val = RS_BADINSN;
						end
					endcase
				end else if (sts.op == OP_BAN && !sts.acc_neg) begin
					cmd.pc_op = PC_NEXT;
				end else if (sts.ind) begin
					if (sts.tgt_bad_ind) begin
						cmd.rs_we  = 1'b1;
						cmd.rs_val = RS_BADADDR;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RSEL_DATA;
						state_d    = S_POINTER;
						done_d     = 1'b0;
					end
				end else if (sts.tgt_bad_dir) begin
					cmd.rs_we  = 1'b1;
					cmd.rs_val = RS_BADADDR;
				end else begin
					resolve = 1'b1;
				end
			end
			S_POINTER: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (sts.data_bad) begin
					cmd.rs_we  = 1'b1;
					cmd.rs_val = RS_BADADDR;
				end else begin
					resolve = 1'b1;
				end
			end
			S_OPERAND: begin
				cmd.acc_op = ACC_ALU;
				cmd.pc_op  = PC_NEXT;
				state_d    = S_IDLE;
				done_d     = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// The operand address sits in the low bits of the word just read.
		if (resolve) begin
			if (act_op == OP_BAN || act_op == OP_BR) begin
				cmd.pc_op = PC_JUMP;
			end else if (act_op == OP_STC) begin
				cmd.wr_sel = WSEL_STORE;
				cmd.acc_op = ACC_ZERO;
				cmd.pc_op  = PC_NEXT;
			end else begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RSEL_DATA;
				state_d    = S_OPERAND;
				done_d     = 1'b0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`AMU_ASSERT(a_done_when_idle, done |-> !busy)
	`AMU_ASSERT(a_short_item, start && !busy && func != FN_EXEC |=> done)
	`AMU_ASSERT(a_no_spurious_done, !busy && !start |=> !done)
	`AMU_ASSERT_NEVER(a_no_item_in_clear, state_q == S_CLEAR && $past(state_q) == S_IDLE)

endmodule

FILE: hw/rtl/accumulator_machine_16bit_unit.sv
// 16-bit accumulator machine with a single-port-write, single-port-read word
// memory. After reset, busy stays high while the memory is filled with all
// ones. An item is taken when start is high and busy is low. The result of a
// load, start or unused func item is presented in the cycle after the
// accepting edge, and so is that of an execute item when the machine is not
// running. An executed instruction keeps busy high through its steps: fetch
// and decode, then the pointer for an indirect target, then the operand. Its
// result follows in the cycle after the last step. The result appears for
// exactly one cycle with done high, and the receiver cannot stall it, so it
// must be captured in that cycle. A new item may be started in the cycle done
// is high.
module accumulator_machine_16bit_unit import amu_pkg::*; #(
	parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [11:0]         load_address,
	input  logic [WORD_W-1:0]   load_word,
	input  logic [WORD_W-1:0]   read_value,
	output logic                done,
	output logic [WORD_W-1:0]   accumulator,
	output logic [PC_OUT_W-1:0] program_counter,
	output logic [2:0]          status,
	output logic                write_valid,
	output logic [WORD_W-1:0]   write_value,
	output logic                read_taken
);

	cmd_t cmd;
	sts_t sts;

	amu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	amu_dpath #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.load_address    (load_address),
		.load_word       (load_word),
		.read_value      (read_value),
		.accumulator     (accumulator),
		.program_counter (program_counter),
		.status          (status),
		.write_valid     (write_valid),
		.write_value     (write_value),
		.read_taken      (read_taken)
	);

endmodule
